// ===== rtl/cicid_pkg.sv =====
// Shared types and constants for the cloud-in-cell image deposit block.
package cicid_pkg;

  localparam int CFG_W   = 9;
  localparam int POS_W   = 21;
  localparam int DENS_W  = 32;
  localparam int IDX_W   = 8;
  localparam int CELL_W  = 48;
  localparam int PART_W  = 42;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  localparam logic FUNC_DEPOSIT = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ROWMUL,
    ST_ROWSAVE,
    ST_WMUL,
    ST_DMUL,
    ST_ACC,
    ST_RREAD,
    ST_RDATA
  } state_e;

endpackage

// ===== rtl/cicid_mul.sv =====
// Shared registered multiplier used by the deposit sequencer.
module cicid_mul
  import cicid_pkg::*;
#(
  parameter int B_W = 18
) (
  input  logic                  clk_i,
  input  logic [DENS_W-1:0]     a_i,
  input  logic [B_W-1:0]        b_i,
  output logic [DENS_W+B_W-1:0] p_o
);

  logic [DENS_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (DENS_W+B_W)'(a_i) * (DENS_W+B_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/cloud_in_cell_image_deposit.sv =====
// Top level: cloud-in-cell deposit into a square accumulator image.
//
//  channel   direction  handshake              payload
//  command   in         start, busy            func_i pos_x_i pos_y_i density_i
//                                              read_col_i read_row_i
//  result    out        done_o (one cycle)     cell_value_o deposited_o
//  config    in         cfg_we_i               cfg_data_i (image_size)
//
// After reset the image is cleared one cell per cycle, all MAX_SIDE*MAX_SIDE
// cells (65536 by default); busy stays high meanwhile, config writes still land.
// Deposit: after decode and the row multiply come four cell updates, each a
// read-modify-write on the single-port image memory and the shared multiplier.
// Read: row multiply, then a memory read. Dropped deposit or out-of-range read:
// done from decode. One transaction at a time; results cannot be stalled.
module cloud_in_cell_image_deposit
  import cicid_pkg::*;
#(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     func_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic [DENS_W-1:0]        density_i,
  input  logic [IDX_W-1:0]         read_col_i,
  input  logic [IDX_W-1:0]         read_row_i,
  output logic                     done_o,
  output logic [CELL_W-1:0]        cell_value_o,
  output logic                     deposited_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  localparam int NW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = FRAC_BITS + 1;
  localparam int MW    = (2 * FRAC_BITS + 2 > NW) ? 2 * FRAC_BITS + 2 : NW;
  localparam int SHIFT = 2 * FRAC_BITS - 8;
  localparam int SW    = POS_W + 1;
  localparam int BW    = SW - FRAC_BITS;
  localparam int HALF  = 1 << (FRAC_BITS - 1);
  localparam int ONE   = 1 << FRAC_BITS;

  state_e state_q, state_d;

  logic [CFG_W-1:0]        cfg_q;
  logic [NW-1:0]           side;
  logic                    func_q;
  logic [POS_W-1:0]        pos_x_q, pos_y_q;
  logic [DENS_W-1:0]       dens_q;
  logic [IDX_W-1:0]        col_q, row_q;
  logic [NW-1:0]           i_q, j_q, ip1_q;
  logic                    jlast_q;
  logic [WW-1:0]           wx_q, wy_q;
  logic [AW-1:0]           jn_q, addr_q, clr_q;
  logic [1:0]              part_q;
  logic [CELL_W-1:0]       rdata_q;
  logic                    done_q, dep_q;
  logic [CELL_W-1:0]       value_q;

  logic [CELL_W-1:0]       mem [DEPTH];
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_addr;
  logic [CELL_W-1:0]       mem_wdata;

  logic [DENS_W-1:0]       mul_a;
  logic [MW-1:0]           mul_b;
  logic [DENS_W+MW-1:0]    mul_p;

  logic [SW-1:0]           sx, sy;
  logic [BW-1:0]           bx, by;
  logic                    okx, oky, dep_ok, rd_ok;
  logic [WW-1:0]           wx_n, wy_n, wx_k, wy_k;
  logic [AW-1:0]           row_k, addr_k;
  logic [NW-1:0]           col_k;
  logic [PART_W-1:0]       part;
  logic [CELL_W:0]         sum;
  logic                    res_fire, res_dep, res_mem;
  logic                    accept;

  assign accept = start && !busy;
  assign side   = (32'(cfg_q) > MAX_SIDE) ? NW'(MAX_SIDE) : NW'(cfg_q);

  // position split: s = pos + 0.5, base = int(s) - 1, low weight = 1 - frac(s)
  always_comb begin
    sx   = {pos_x_q[POS_W-1], pos_x_q} + SW'(HALF);
    sy   = {pos_y_q[POS_W-1], pos_y_q} + SW'(HALF);
    bx   = sx[SW-1:FRAC_BITS] - BW'(1);
    by   = sy[SW-1:FRAC_BITS] - BW'(1);
    okx  = !sx[SW-1] && (sx[SW-1:FRAC_BITS] != '0) && (32'(bx) < 32'(side));
    oky  = !sy[SW-1] && (sy[SW-1:FRAC_BITS] != '0) && (32'(by) < 32'(side));
    wx_n = WW'(ONE) - {1'b0, sx[FRAC_BITS-1:0]};
    wy_n = WW'(ONE) - {1'b0, sy[FRAC_BITS-1:0]};
    dep_ok = okx && oky;
    rd_ok  = (32'(col_q) < 32'(side)) && (32'(row_q) < 32'(side));
  end

  always_comb begin
    wx_k   = part_q[0] ? WW'(ONE) - wx_q : wx_q;
    wy_k   = part_q[1] ? WW'(ONE) - wy_q : wy_q;
    col_k  = part_q[0] ? ip1_q : i_q;
    row_k  = part_q[1] ? (jlast_q ? jn_q : jn_q + AW'(side)) : jn_q;
    addr_k = AW'(col_k) + row_k;
    part   = mul_p[SHIFT+PART_W-1:SHIFT];
    sum    = {1'b0, rdata_q} + (CELL_W+1)'(part);
  end

  cicid_mul #(
    .B_W(MW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:    if (start) state_d = ST_DECODE;
      ST_DECODE: begin
        if (func_q == FUNC_READ) state_d = rd_ok ? ST_ROWMUL : ST_IDLE;
        else                     state_d = dep_ok ? ST_ROWMUL : ST_IDLE;
      end
      ST_ROWMUL:  state_d = ST_ROWSAVE;
      ST_ROWSAVE: state_d = (func_q == FUNC_READ) ? ST_RREAD : ST_WMUL;
      ST_WMUL:    state_d = ST_DMUL;
      ST_DMUL:    state_d = ST_ACC;
      ST_ACC:     state_d = (part_q == 2'd3) ? ST_IDLE : ST_WMUL;
      ST_RREAD:   state_d = ST_RDATA;
      ST_RDATA:   state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = sum[CELL_W] ? '1 : sum[CELL_W-1:0];
    mul_a     = 32'(j_q);
    mul_b     = MW'(side);
    res_fire  = 1'b0;
    res_dep   = 1'b0;
    res_mem   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      ST_DECODE: begin
        res_fire = (func_q == FUNC_READ) ? !rd_ok : !dep_ok;
      end
      ST_WMUL: begin
        mem_re   = 1'b1;
        mem_addr = addr_k;
        mul_a    = 32'(wx_k);
        mul_b    = MW'(wy_k);
      end
      ST_DMUL: begin
        mul_a = dens_q;
        mul_b = MW'(mul_p[2*FRAC_BITS+1:0]);
      end
      ST_ACC: begin
        mem_we   = 1'b1;
        res_fire = (part_q == 2'd3);
        res_dep  = 1'b1;
      end
      ST_RREAD: begin
        mem_re   = 1'b1;
        mem_addr = AW'(i_q) + jn_q;
      end
      ST_RDATA: begin
        res_fire = 1'b1;
        res_mem  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cfg_q   <= SIZE_RESET;
      clr_q   <= '0;
      part_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= res_fire;
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == ST_ROWMUL) part_q <= '0;
      else if (state_q == ST_ACC) part_q <= part_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      dens_q  <= density_i;
      col_q   <= read_col_i;
      row_q   <= read_row_i;
    end
    if (state_q == ST_DECODE) begin
      if (func_q == FUNC_READ) begin
        i_q <= NW'(col_q);
        j_q <= NW'(row_q);
      end else begin
        i_q <= NW'(bx);
        j_q <= NW'(by);
      end
      wx_q <= wx_n;
      wy_q <= wy_n;
    end
    if (state_q == ST_ROWMUL) begin
      ip1_q   <= (32'(i_q) + 1 < 32'(side)) ? i_q + NW'(1) : side - NW'(1);
      jlast_q <= !(32'(j_q) + 1 < 32'(side));
    end
    if (state_q == ST_ROWSAVE) jn_q <= AW'(mul_p);
    if (state_q == ST_WMUL) addr_q <= addr_k;
    if (res_fire) begin
      value_q <= res_mem ? rdata_q : '0;
      dep_q   <= res_dep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign cell_value_o = value_q;
  assign deposited_o  = dep_q;

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q != ST_IDLE))
    else $error("result strobe without a transaction in progress");

  a_dep_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && deposited_o) |-> (cell_value_o == '0))
    else $error("deposit result carries a cell value");

  a_acc_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> ($past(state_q) == ST_DMUL))
    else $error("accumulate without product");

  a_no_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result one cycle after accept");

endmodule
